@@ hw/rtl/plr2t_pkg.sv @@
// plr2t_pkg: shared constants for the radiometric raw-to-temperature pipeline
// register indexes, status codes and fixed-point constants; no dependencies
package plr2t_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_R1 = 3'd0;
  localparam logic [2:0] CFG_R2 = 3'd1;
  localparam logic [2:0] CFG_B  = 3'd2;
  localparam logic [2:0] CFG_F  = 3'd3;
  localparam logic [2:0] CFG_O  = 3'd4;
  localparam logic [2:0] CFG_LO = 3'd5;
  localparam logic [2:0] CFG_HI = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DOMAIN = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  // log2(e) in Q.32 and 273.15 in Q.8
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic signed [59:0] KELVIN_OFFSET_Q8 = 60'sd69926;
  localparam logic signed [59:0] TEMP_MAX = 60'sd8388607;
  localparam logic signed [59:0] TEMP_MIN = -60'sd8388608;

endpackage

@@ hw/rtl/plr2t_div.sv @@
// plr2t_div: pipelined restoring divider, one quotient bit per stage
// standalone; instantiated by planck_raw_to_temperature_top
module plr2t_div #(
  parameter int NUM_W  = 96,
  parameter int DEN_W  = 65,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              stg_valid [NUM_W];
  logic [DEN_W-1:0]  rem       [NUM_W];
  logic [NUM_W-1:0]  nq        [NUM_W];
  logic [DEN_W-1:0]  dreg      [NUM_W];
  logic [SIDE_W-1:0] sreg      [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  r_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign r_in  = '0;
      assign nq_in = num;
      assign d_in  = den;
      assign s_in  = side_in;
    end else begin : g_next
      assign v_in  = stg_valid[i-1];
      assign r_in  = rem[i-1];
      assign nq_in = nq[i-1];
      assign d_in  = dreg[i-1];
      assign s_in  = sreg[i-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {r_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[i] <= 1'b0;
      end else if (advance) begin
        stg_valid[i] <= v_in;
      end
      if (advance) begin
        rem[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[i]   <= {nq_in[NUM_W-2:0], ge};
        dreg[i] <= d_in;
        sreg[i] <= s_in;
      end
    end
  end

  assign out_valid = stg_valid[NUM_W-1];
  assign quo       = nq[NUM_W-1];
  assign side_out  = sreg[NUM_W-1];

endmodule

@@ hw/rtl/planck_raw_to_temperature_top.sv @@
// planck_raw_to_temperature_top: pixel raw value to Celsius, one word per
// clock while in_stall is low; depends on plr2t_pkg and plr2t_div
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    raw_pixel
// out      output     out_valid / out_stall  temperature_c, status
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// on its way from input to output a word passes the NF fold stages of the
// span mapping (5 at PIXEL_BITS 16), the two bit-serial division pipelines
// (96 and 58 stages) and the 32 log squaring stages. one word enters every
// clock while in_stall is low.
// synchronous reset clears all valid bits and loads the register defaults.
// the whole pipeline holds while the output word is stalled; nothing is lost.
module planck_raw_to_temperature_top #(
  parameter int PIXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        raw_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] temperature_c,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int PW      = PIXEL_BITS;
  localparam int NW      = 34 + PW;
  localparam int NF      = (NW + PW - 1) / PW + 1;
  localparam int T_W     = 36;
  localparam logic [NW-1:0] PMAX = NW'((64'd1 << PW) - 64'd1);
  localparam logic [NW-1:0] HALF = NW'((64'd1 << (PW - 1)) - 64'd1);

  // configuration registers
  logic [31:0]        r1;
  logic [31:0]        r2;
  logic [23:0]        b;
  logic [23:0]        f;
  logic signed [24:0] o;
  logic signed [31:0] lo;
  logic signed [31:0] hi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1 <= 32'd4194304;
      r2 <= 32'd85899346;
      b  <= 24'd368640;
      f  <= 24'd65536;
      o  <= -25'sd1536000;
      lo <= 32'sd0;
      hi <= 32'sd16776960;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        plr2t_pkg::CFG_R1: r1 <= cfg_data;
        plr2t_pkg::CFG_R2: r2 <= cfg_data;
        plr2t_pkg::CFG_B:  b  <= cfg_data[23:0];
        plr2t_pkg::CFG_F:  f  <= cfg_data[23:0];
        plr2t_pkg::CFG_O:  o  <= $signed(cfg_data[24:0]);
        plr2t_pkg::CFG_LO: lo <= $signed(cfg_data);
        plr2t_pkg::CFG_HI: hi <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output word is held
  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage 1: span times pixel
  logic signed [32:0] span;
  logic               s1_valid;
  logic signed [NW-1:0] s1_prod;
  assign span = 33'(hi) - 33'(lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
    if (advance) begin
      s1_prod <= NW'(span) * NW'($signed({1'b0, raw_pixel[PW-1:0]}));
    end
  end

  // stage 2: magnitude plus rounding half
  logic          s2_valid;
  logic [NW-1:0] s2_n;
  logic          s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_n   <= (s1_prod[NW-1] ? NW'(-s1_prod) : NW'(s1_prod)) + HALF;
      s2_neg <= s1_prod[NW-1];
    end
  end

  // fold stages: divide by 2^PW - 1 by folding high digits onto low ones
  logic          fd_valid [NF];
  logic [NW-1:0] fd_n     [NF];
  logic [NW-1:0] fd_q     [NF];
  logic          fd_neg   [NF];

  for (genvar i = 0; i < NF; i++) begin : g_fold
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic          neg_in;
    logic [NW-1:0] upper;

    if (i == 0) begin : g_first
      assign v_in   = s2_valid;
      assign n_in   = s2_n;
      assign q_in   = '0;
      assign neg_in = s2_neg;
    end else begin : g_next
      assign v_in   = fd_valid[i-1];
      assign n_in   = fd_n[i-1];
      assign q_in   = fd_q[i-1];
      assign neg_in = fd_neg[i-1];
    end

    assign upper = n_in >> PW;

    always_ff @(posedge clk) begin
      if (rst) begin
        fd_valid[i] <= 1'b0;
      end else if (advance) begin
        fd_valid[i] <= v_in;
      end
      if (advance) begin
        fd_q[i]   <= q_in + upper;
        fd_n[i]   <= upper + (n_in & PMAX);
        fd_neg[i] <= neg_in;
      end
    end
  end

  // final correction of the fold quotient
  logic          sc_valid;
  logic [NW-1:0] sc_step;
  logic          sc_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (advance) begin
      sc_valid <= fd_valid[NF-1];
    end
    if (advance) begin
      sc_step <= fd_q[NF-1] + ((fd_n[NF-1] >= PMAX) ? NW'(1) : NW'(0));
      sc_neg  <= fd_neg[NF-1];
    end
  end

  // object raw plus offset, domain check
  logic signed [T_W-1:0] step_s;
  logic signed [T_W-1:0] t_sum;
  logic                  st_valid;
  logic [32:0]           st_t;
  logic                  st_err;

  assign step_s = $signed({1'b0, sc_step[T_W-2:0]});
  assign t_sum  = T_W'(lo) + (sc_neg ? -step_s : step_s) + T_W'(o);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (advance) begin
      st_valid <= sc_valid;
    end
    if (advance) begin
      st_t   <= t_sum[32:0];
      st_err <= t_sum[T_W-1] || (t_sum == '0) || (r2 == 32'd0);
    end
  end

  // denominator R2 * t
  logic        sd_valid;
  logic [64:0] sd_den;
  logic        sd_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (advance) begin
      sd_valid <= st_valid;
    end
    if (advance) begin
      sd_den <= st_err ? 65'd1 : 65'(r2) * 65'(st_t);
      sd_err <= st_err;
    end
  end

  // R1 * 2^64 / (R2 * t)
  logic        d1_valid;
  logic [95:0] d1_quo;
  logic        d1_err;

  plr2t_div #(
    .NUM_W  (96),
    .DEN_W  (65),
    .SIDE_W (1)
  ) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (sd_valid),
    .num       ({r1, 64'd0}),
    .den       (sd_den),
    .side_in   (sd_err),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .side_out  (d1_err)
  );

  // add F and check for a zero log argument
  logic [96:0] q_sum;
  logic        sq_valid;
  logic [96:0] sq_q;
  logic        sq_err;

  assign q_sum = 97'(d1_quo) + 97'({f, 16'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (advance) begin
      sq_valid <= d1_valid;
    end
    if (advance) begin
      sq_q   <= q_sum;
      sq_err <= d1_err || (q_sum == '0);
    end
  end

  // normalize: binary search for the leading one, 64 down to 1
  logic        nm_valid [7];
  logic [96:0] nm_x     [7];
  logic [6:0]  nm_lz    [7];
  logic        nm_err   [7];

  for (genvar i = 0; i < 7; i++) begin : g_norm
    localparam int SH = 1 << (6 - i);
    logic        v_in;
    logic [96:0] x_in;
    logic [6:0]  lz_in;
    logic        err_in;
    logic        top_zero;

    if (i == 0) begin : g_first
      assign v_in   = sq_valid;
      assign x_in   = sq_q;
      assign lz_in  = '0;
      assign err_in = sq_err;
    end else begin : g_next
      assign v_in   = nm_valid[i-1];
      assign x_in   = nm_x[i-1];
      assign lz_in  = nm_lz[i-1];
      assign err_in = nm_err[i-1];
    end

    assign top_zero = (x_in[96 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nm_valid[i] <= 1'b0;
      end else if (advance) begin
        nm_valid[i] <= v_in;
      end
      if (advance) begin
        nm_x[i]   <= top_zero ? (x_in << SH) : x_in;
        nm_lz[i]  <= top_zero ? (lz_in + 7'(SH)) : lz_in;
        nm_err[i] <= err_in;
      end
    end
  end

  // log2 fraction: one squaring per stage
  logic        lg_valid [32];
  logic [31:0] lg_man   [32];
  logic [31:0] lg_frac  [32];
  logic [6:0]  lg_lz    [32];
  logic        lg_err   [32];

  for (genvar i = 0; i < 32; i++) begin : g_log
    logic        v_in;
    logic [31:0] man_in;
    logic [31:0] frac_in;
    logic [6:0]  lz_in;
    logic        err_in;
    logic [63:0] sqr;
    logic [32:0] z;

    if (i == 0) begin : g_first
      assign v_in    = nm_valid[6];
      assign man_in  = nm_x[6][96:65];
      assign frac_in = '0;
      assign lz_in   = nm_lz[6];
      assign err_in  = nm_err[6];
    end else begin : g_next
      assign v_in    = lg_valid[i-1];
      assign man_in  = lg_man[i-1];
      assign frac_in = lg_frac[i-1];
      assign lz_in   = lg_lz[i-1];
      assign err_in  = lg_err[i-1];
    end

    assign sqr = man_in * man_in;
    assign z   = sqr[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        lg_valid[i] <= 1'b0;
      end else if (advance) begin
        lg_valid[i] <= v_in;
      end
      if (advance) begin
        lg_man[i]  <= z[32] ? z[32:1] : z[31:0];
        lg_frac[i] <= {frac_in[30:0], z[32]};
        lg_lz[i]   <= lz_in;
        lg_err[i]  <= err_in;
      end
    end
  end

  // assemble L, take its magnitude, form B * log2(e)
  logic [6:0]         msb_pos;
  logic signed [7:0]  expo;
  logic signed [39:0] l_val;
  logic [39:0]        l_mag;
  logic               l_err;
  logic               sl_valid;
  logic [38:0]        sl_mag;
  logic               sl_neg;
  logic               sl_err;
  logic [56:0]        sl_bn;

  assign msb_pos = 7'd96 - lg_lz[31];
  assign expo    = $signed({1'b0, msb_pos}) - 8'sd32;
  assign l_val   = {expo, lg_frac[31]};
  assign l_mag   = l_val[39] ? 40'(-l_val) : 40'(l_val);
  assign l_err   = lg_err[31] || (l_val == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sl_valid <= 1'b0;
    end else if (advance) begin
      sl_valid <= lg_valid[31];
    end
    if (advance) begin
      sl_mag <= l_err ? 39'd1 : l_mag[38:0];
      sl_neg <= l_val[39];
      sl_err <= l_err;
      sl_bn  <= 57'(b) * 57'(plr2t_pkg::LOG2E_Q32);
    end
  end

  // rounding numerator for the kelvin division
  logic        sn_valid;
  logic [57:0] sn_num;
  logic [38:0] sn_den;
  logic [1:0]  sn_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sn_valid <= 1'b0;
    end else if (advance) begin
      sn_valid <= sl_valid;
    end
    if (advance) begin
      sn_num  <= 58'(sl_bn) + 58'(sl_mag >> 1);
      sn_den  <= sl_mag;
      sn_side <= {sl_neg, sl_err};
    end
  end

  // kelvin = B * log2(e) / L
  logic        d2_valid;
  logic [57:0] d2_quo;
  logic [1:0]  d2_side;

  plr2t_div #(
    .NUM_W  (58),
    .DEN_W  (39),
    .SIDE_W (2)
  ) u_div_kelvin (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (sn_valid),
    .num       (sn_num),
    .den       (sn_den),
    .side_in   (sn_side),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .side_out  (d2_side)
  );

  // celsius, saturation and output word register
  logic signed [59:0] tk;
  logic signed [59:0] tc;
  logic signed [23:0] res_temp;
  logic [1:0]         res_status;

  assign tk = d2_side[1] ? -$signed({2'b00, d2_quo}) : $signed({2'b00, d2_quo});
  assign tc = tk - plr2t_pkg::KELVIN_OFFSET_Q8;

  always_comb begin
    priority if (d2_side[0]) begin
      res_temp   = '0;
      res_status = plr2t_pkg::ST_DOMAIN;
    end else if (tc > plr2t_pkg::TEMP_MAX) begin
      res_temp   = 24'sh7FFFFF;
      res_status = plr2t_pkg::ST_SAT;
    end else if (tc < plr2t_pkg::TEMP_MIN) begin
      res_temp   = -24'sh800000;
      res_status = plr2t_pkg::ST_SAT;
    end else begin
      res_temp   = tc[23:0];
      res_status = plr2t_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= d2_valid;
    end
    if (advance) begin
      temperature_c <= res_temp;
      status        <= res_status;
    end
  end

endmodule
